### rtl/cesa_pkg.sv
package cesa_pkg;

    localparam int MAX_THREADS = 16;
    localparam int MAX_DEPTH   = 32;

    localparam int SLOT_W   = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int USED_W   = $clog2(MAX_THREADS + 1);
    localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
    localparam int NFRAMES  = MAX_THREADS * MAX_DEPTH;
    localparam int FRAME_AW = (NFRAMES > 1) ? $clog2(NFRAMES) : 1;
    localparam int FRAME_W  = 64 + 64 + 32;

    // splitmix64 constants
    localparam logic [63:0] GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX2  = 64'h94D0_49BB_1331_11EB;

    // configuration register indexes
    localparam logic [1:0] REG_SEED   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam logic MODE_ENTER = 1'b0;

    typedef enum logic [1:0] {
        DEST_HIGH,
        DEST_LOW,
        DEST_SPAN
    } id_dest_t;

    typedef struct packed {
        logic               mode;
        logic [63:0]        thread_id;
        logic [63:0]        timestamp;
        logic signed [31:0] method_index;
        logic               last_in_batch;
    } event_t;

    typedef struct packed {
        logic [63:0]        trace_id_high;
        logic [63:0]        trace_id_low;
        logic [63:0]        span_id;
        logic [63:0]        parent_id;
        logic               nested;
        logic signed [31:0] span_method;
        logic [63:0]        start_time;
        logic [63:0]        end_time;
    } span_t;

    typedef struct packed {
        logic       capture;
        logic       search_next;
        logic       new_slot;
        logic       pop;
        logic       draw_add;
        logic       mul_en;
        logic [1:0] mul_phase;
        logic       mul_sel2;
        logic       mix27;
        logic       store_id;
        id_dest_t   dest;
        logic       rd_par;
        logic       cap_cur;
        logic       cap_par;
        logic       emit;
        logic       finish;
    } cesa_cmd_t;

    typedef struct packed {
        logic match;
        logic more;
        logic full;
        logic mode;
        logic d_zero;
        logic d_full;
        logic under_limit;
        logic out_busy;
    } cesa_status_t;

endpackage

### rtl/cesa_ram.sv
module cesa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/cesa_ctrl.sv
module cesa_ctrl
    import cesa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         evt_valid,
    output logic         evt_ready,
    input  cesa_status_t status,
    output cesa_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_SEARCH, S_DISPATCH, S_ADD,
        S_M1A, S_M1B, S_M1C, S_X27, S_M2A, S_M2B, S_M2C, S_STORE,
        S_RD_CUR, S_RD_WAIT, S_RD_PAR, S_EMIT, S_FINISH
    } state_t;

    state_t   state_reg, state_next;
    id_dest_t dest_reg, dest_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dest_reg  <= DEST_HIGH;
        end
        else
        begin
            state_reg <= state_next;
            dest_reg  <= dest_next;
        end
    end

    assign evt_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        dest_next  = dest_reg;
        cmd        = '0;
        cmd.dest   = dest_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                priority if (status.match)
                begin
                    state_next = S_DISPATCH;
                end
                else if (status.more)
                begin
                    cmd.search_next = 1'b1;
                end
                else if (!status.full)
                begin
                    cmd.new_slot = 1'b1;
                    state_next   = S_DISPATCH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DISPATCH:
            begin
                if (status.mode == MODE_ENTER)
                begin
                    if (status.d_full)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        dest_next  = status.d_zero ? DEST_HIGH : DEST_SPAN;
                        state_next = S_ADD;
                    end
                end
                else if (status.d_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = status.under_limit ? S_RD_CUR : S_FINISH;
                end
            end
            S_ADD:
            begin
                cmd.draw_add = 1'b1;
                state_next   = S_M1A;
            end
            S_M1A:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = 2'd0;
                state_next    = S_M1B;
            end
            S_M1B:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = 2'd1;
                state_next    = S_M1C;
            end
            S_M1C:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = 2'd2;
                state_next    = S_X27;
            end
            S_X27:
            begin
                cmd.mix27  = 1'b1;
                state_next = S_M2A;
            end
            S_M2A:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel2  = 1'b1;
                cmd.mul_phase = 2'd0;
                state_next    = S_M2B;
            end
            S_M2B:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel2  = 1'b1;
                cmd.mul_phase = 2'd1;
                state_next    = S_M2C;
            end
            S_M2C:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel2  = 1'b1;
                cmd.mul_phase = 2'd2;
                state_next    = S_STORE;
            end
            S_STORE:
            begin
                cmd.store_id = 1'b1;
                unique case (dest_reg)
                    DEST_HIGH:
                    begin
                        dest_next  = DEST_LOW;
                        state_next = S_ADD;
                    end
                    DEST_LOW:
                    begin
                        dest_next  = DEST_SPAN;
                        state_next = S_ADD;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_RD_CUR:
            begin
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                cmd.cap_cur = 1'b1;
                cmd.rd_par  = 1'b1;
                state_next  = S_RD_PAR;
            end
            S_RD_PAR:
            begin
                cmd.cap_par = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/cesa_dp.sv
module cesa_dp
    import cesa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  event_t       evt,
    input  logic         cfg_valid,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    output span_t        span,
    output logic         span_valid,
    input  logic         span_ready,
    input  cesa_cmd_t    cmd,
    output cesa_status_t status
);

    // configuration
    logic [63:0] seed_reg, offset_reg;
    logic [15:0] limit_reg;

    // batch state
    logic              in_batch_reg;
    logic [63:0]       rng_reg;
    logic [USED_W-1:0] used_reg;
    logic [15:0]       emitted_reg;

    // current item
    event_t            item_reg;
    logic [63:0]       when_reg;
    logic [USED_W-1:0] slot_reg;

    // thread slots
    logic [63:0]        thread_reg [MAX_THREADS];
    logic [DEPTH_W-1:0] depth_reg  [MAX_THREADS];
    logic [63:0]        thi_reg    [MAX_THREADS];
    logic [63:0]        tlo_reg    [MAX_THREADS];

    // id generator
    logic [63:0] z_reg, acc_reg;

    logic [FRAME_W-1:0] cur_reg;
    logic [63:0]        par_reg;
    logic               out_valid_reg;
    span_t              out_reg;

    logic [SLOT_W-1:0]   idx;
    logic [DEPTH_W-1:0]  d_cur, d_sel;
    logic [FRAME_AW-1:0] base, raddr, waddr;
    logic [FRAME_W-1:0]  rdata;
    logic [63:0]         s_add, mul_b, id_out, mul_part;
    logic [31:0]         mul_x, mul_y;

    assign idx   = slot_reg[SLOT_W-1:0];
    assign d_cur = depth_reg[idx];
    assign base  = FRAME_AW'(idx * MAX_DEPTH);
    assign d_sel = cmd.rd_par ? d_cur - 1'b1 : d_cur;
    assign raddr = base + FRAME_AW'(d_sel);
    assign waddr = base + FRAME_AW'(d_cur);

    assign s_add  = rng_reg + GAMMA;
    assign id_out = acc_reg ^ (acc_reg >> 31);
    assign mul_b  = cmd.mul_sel2 ? MIX2 : MIX1;

    always_comb
    begin
        unique case (cmd.mul_phase)
            2'd0:
            begin
                mul_x = z_reg[31:0];
                mul_y = mul_b[31:0];
            end
            2'd1:
            begin
                mul_x = z_reg[31:0];
                mul_y = mul_b[63:32];
            end
            default:
            begin
                mul_x = z_reg[63:32];
                mul_y = mul_b[31:0];
            end
        endcase
        mul_part = mul_x * mul_y;
    end

    cesa_ram #(
        .WIDTH(FRAME_W),
        .DEPTH(NFRAMES)
    ) u_frames (
        .clk  (clk),
        .we   (cmd.store_id && cmd.dest == DEST_SPAN),
        .waddr(waddr),
        .wdata({id_out, when_reg, item_reg.method_index}),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign status.more        = slot_reg < used_reg;
    assign status.match       = status.more && (thread_reg[idx] == item_reg.thread_id);
    assign status.full        = used_reg == USED_W'(MAX_THREADS);
    assign status.mode        = item_reg.mode;
    assign status.d_zero      = d_cur == '0;
    assign status.d_full      = d_cur == DEPTH_W'(MAX_DEPTH);
    assign status.under_limit = emitted_reg < limit_reg;
    assign status.out_busy    = out_valid_reg && !span_ready;

    assign span       = out_reg;
    assign span_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            offset_reg    <= '0;
            limit_reg     <= 16'hFFFF;
            in_batch_reg  <= 1'b0;
            rng_reg       <= '0;
            used_reg      <= '0;
            emitted_reg   <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SEED:   seed_reg   <= cfg_data;
                    REG_OFFSET: offset_reg <= cfg_data;
                    REG_LIMIT:  limit_reg  <= cfg_data[15:0];
                    default:    ;
                endcase
            end
            if (cmd.capture)
            begin
                slot_reg <= '0;
                if (!in_batch_reg)
                begin
                    in_batch_reg <= 1'b1;
                    rng_reg      <= seed_reg;
                    used_reg     <= '0;
                    emitted_reg  <= '0;
                end
            end
            if (cmd.search_next)
            begin
                slot_reg <= slot_reg + 1'b1;
            end
            if (cmd.new_slot)
            begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.draw_add)
            begin
                rng_reg <= s_add;
            end
            if (cmd.finish && item_reg.last_in_batch)
            begin
                in_batch_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                emitted_reg   <= emitted_reg + 1'b1;
            end
            else if (span_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= evt;
            when_reg <= evt.timestamp + offset_reg;
        end
        if (cmd.new_slot)
        begin
            thread_reg[idx] <= item_reg.thread_id;
            depth_reg[idx]  <= '0;
        end
        if (cmd.pop)
        begin
            depth_reg[idx] <= d_cur - 1'b1;
        end
        if (cmd.draw_add)
        begin
            z_reg <= s_add ^ (s_add >> 30);
        end
        if (cmd.mix27)
        begin
            z_reg <= acc_reg ^ (acc_reg >> 27);
        end
        if (cmd.mul_en)
        begin
            if (cmd.mul_phase == 2'd0)
            begin
                acc_reg <= mul_part;
            end
            else
            begin
                acc_reg <= acc_reg + {mul_part[31:0], 32'd0};
            end
        end
        if (cmd.store_id)
        begin
            unique case (cmd.dest)
                DEST_HIGH: thi_reg[idx] <= id_out;
                DEST_LOW:  tlo_reg[idx] <= id_out;
                default:   depth_reg[idx] <= d_cur + 1'b1;
            endcase
        end
        if (cmd.cap_cur)
        begin
            cur_reg <= rdata;
        end
        if (cmd.cap_par)
        begin
            par_reg <= status.d_zero ? 64'd0 : rdata[FRAME_W-1 -: 64];
        end
        if (cmd.emit)
        begin
            out_reg.trace_id_high <= thi_reg[idx];
            out_reg.trace_id_low  <= tlo_reg[idx];
            out_reg.span_id       <= cur_reg[FRAME_W-1 -: 64];
            out_reg.parent_id     <= par_reg;
            out_reg.nested        <= !status.d_zero;
            out_reg.span_method   <= cur_reg[31:0];
            out_reg.start_time    <= cur_reg[95:32];
            out_reg.end_time      <= when_reg;
        end
    end

endmodule

### rtl/call_event_span_assembler.sv
// Channel | Direction | Handshake               | Item
// evt     | in        | evt_valid / evt_ready   | event_t: enter or exit of one thread
// span    | out       | span_valid / span_ready | span_t: one finished span
// cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data register write
//
// One event at a time. The slot search compares one slot per cycle; an enter draws
// one or three ids, each through the shared 32x32 multiplier that builds each 64-bit
// product in three partial steps. An exit that emits makes two frame memory reads.
// Reset clears control state only; the stores need no clearing pass.
// A finished span waits in the output register while the next event is taken;
// only a second span stalls the sequencer until the first is taken.
module call_event_span_assembler
    import cesa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        evt_valid,
    output logic        evt_ready,
    input  event_t      evt,
    output logic        span_valid,
    input  logic        span_ready,
    output span_t       span,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cesa_cmd_t    cmd;
    cesa_status_t status;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    cesa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt_valid(evt_valid),
        .evt_ready(evt_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cesa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .span      (span),
        .span_valid(span_valid),
        .span_ready(span_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### rtl/cesa_chk.sv
module cesa_chk
    import cesa_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  evt_valid,
    input logic  evt_ready,
    input logic  span_valid,
    input logic  span_ready,
    input span_t span,
    input logic  cfg_ready
);

    // held span keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && !span_ready |=> span_valid && $stable(span))
        else $error("span changed while stalled");

    // an accepted event leaves the sequencer busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
        else $error("event taken while busy");

    // a new span only appears while an event is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(span_valid) |-> $past(!evt_ready))
        else $error("span without event in work");

    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port stalled");

endmodule

bind call_event_span_assembler cesa_chk u_cesa_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .span_valid(span_valid),
    .span_ready(span_ready),
    .span      (span),
    .cfg_ready (cfg_ready)
);
